### rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed: invariant");

// implication checked against the clock, outside reset
`define ASSERT_IMPLY(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed: implication");

`endif

### rtl/stcls_pkg.sv
// types, constants and character class functions of the token classifier
package stcls_pkg;

   localparam int MAX_TOKEN_LENGTH_DEF = 255;
   localparam int OUT_LEN_W            = 8;
   localparam int OUT_LEN_MAX          = 255;
   localparam int RSP_QUEUE_DEPTH      = 4;
   localparam int RSP_QUEUE_CNT_W      = 3;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_OPEN   = 8'h28;
   localparam logic [7:0] CH_CLOSE  = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SEMI   = 8'h3B;

   typedef enum logic [3:0] {
      KIND_DOT    = 4'd0,
      KIND_COMMA  = 4'd1,
      KIND_OPEN   = 4'd2,
      KIND_CLOSE  = 4'd3,
      KIND_QUOTE  = 4'd4,
      KIND_NUMBER = 4'd5,
      KIND_SYMBOL = 4'd6,
      KIND_BAD    = 4'd7,
      KIND_END    = 4'd8
   } kind_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      kind_type              token_kind;
      logic [OUT_LEN_W-1:0]  token_length;
      logic                  last_of_run;
   } rsp_type;

   // results of one item, compacted: count is 0, 1 or 2
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } res_pair_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
             ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   // c-locale whitespace: space, tab, lf, vt, ff, cr
   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      return (c == CH_OPEN) || (c == CH_DOT) || (c == CH_COMMA) ||
             (c == CH_SEMI) || (c == CH_CLOSE) || (c == CH_LF);
   endfunction

   function automatic logic is_trim(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
   endfunction

   function automatic logic is_single(input logic [7:0] c);
      return (c == CH_DOT) || (c == CH_COMMA) || (c == CH_OPEN) ||
             (c == CH_CLOSE) || (c == CH_QUOTE);
   endfunction

   function automatic kind_type single_kind(input logic [7:0] c);
      kind_type k;
      unique case (c)
         CH_DOT:   k = KIND_DOT;
         CH_COMMA: k = KIND_COMMA;
         CH_OPEN:  k = KIND_OPEN;
         CH_CLOSE: k = KIND_CLOSE;
         default:  k = KIND_QUOTE;
      endcase
      return k;
   endfunction

endpackage

### rtl/stcls_lexer.sv
// lexer state and per-byte token logic
`include "assert_macros.svh"

module stcls_lexer #(
   parameter int MAX_TOKEN_LENGTH = stcls_pkg::MAX_TOKEN_LENGTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  stcls_pkg::req_type      item,
   output stcls_pkg::res_pair_type res
);

   localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);
   localparam int EXT_W = (LEN_W > stcls_pkg::OUT_LEN_W) ? LEN_W : stcls_pkg::OUT_LEN_W;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_RUN,
      MODE_COMMENT
   } mode_type;

   mode_type         mode_ff, mode_in;
   logic [LEN_W-1:0] kept_ff, kept_in;
   logic [LEN_W-1:0] pend_ff, pend_in;
   logic             tabcr_ff, tabcr_in;
   logic             sign_ff, sign_in;
   logic             digit_ff, digit_in;
   logic             num_ok_ff, num_ok_in;
   logic             sym_ok_ff, sym_ok_in;

   logic [7:0]       c;
   logic [LEN_W:0]   kept_sum, pend_sum;
   logic [LEN_W-1:0] kept_sat, pend_sat;
   logic [EXT_W-1:0] kept_ext;
   stcls_pkg::rsp_type run_tok, end_tok, single_tok;
   stcls_pkg::rsp_type first, second;
   logic [1:0]       n;

   assign c = item.char_byte;

   assign kept_sum = (LEN_W+1)'(kept_ff) + (LEN_W+1)'(pend_ff) + (LEN_W+1)'(1);
   assign pend_sum = (LEN_W+1)'(pend_ff) + (LEN_W+1)'(1);
   assign kept_sat = (kept_sum > (LEN_W+1)'(MAX_TOKEN_LENGTH)) ?
                     LEN_W'(MAX_TOKEN_LENGTH) : kept_sum[LEN_W-1:0];
   assign pend_sat = (pend_sum > (LEN_W+1)'(MAX_TOKEN_LENGTH)) ?
                     LEN_W'(MAX_TOKEN_LENGTH) : pend_sum[LEN_W-1:0];
   assign kept_ext = EXT_W'(kept_ff);

   always_comb begin
      run_tok.last_of_run = 1'b0;
      run_tok.token_length = (kept_ext > EXT_W'(stcls_pkg::OUT_LEN_MAX)) ?
                             stcls_pkg::OUT_LEN_W'(stcls_pkg::OUT_LEN_MAX) :
                             kept_ext[stcls_pkg::OUT_LEN_W-1:0];
      priority if (num_ok_ff && digit_ff) begin
         run_tok.token_kind = stcls_pkg::KIND_NUMBER;
      end else if (sym_ok_ff) begin
         run_tok.token_kind = stcls_pkg::KIND_SYMBOL;
      end else begin
         run_tok.token_kind = stcls_pkg::KIND_BAD;
      end
   end

   assign end_tok    = '{token_kind: stcls_pkg::KIND_END, token_length: '0,
                         last_of_run: 1'b0};
   assign single_tok = '{token_kind: stcls_pkg::single_kind(c),
                         token_length: stcls_pkg::OUT_LEN_W'(1), last_of_run: 1'b0};

   always_comb begin
      mode_in   = mode_ff;
      kept_in   = kept_ff;
      pend_in   = pend_ff;
      tabcr_in  = tabcr_ff;
      sign_in   = sign_ff;
      digit_in  = digit_ff;
      num_ok_in = num_ok_ff;
      sym_ok_in = sym_ok_ff;
      first     = run_tok;
      second    = end_tok;
      n         = 2'd0;

      if (item.end_of_input) begin
         if (mode_ff == MODE_RUN) begin
            first = run_tok;
            n     = 2'd2;
         end else begin
            first = end_tok;
            n     = 2'd1;
         end
         mode_in   = MODE_IDLE;
         kept_in   = '0;
         pend_in   = '0;
         tabcr_in  = 1'b0;
         sign_in   = 1'b0;
         digit_in  = 1'b0;
         num_ok_in = 1'b0;
         sym_ok_in = 1'b0;
      end else begin
         unique case (mode_ff)
            MODE_RUN: begin
               priority if (stcls_pkg::is_delim(c)) begin
                  // flush the run, then treat the delimiter as an idle byte
                  first     = run_tok;
                  n         = 2'd1;
                  mode_in   = MODE_IDLE;
                  kept_in   = '0;
                  pend_in   = '0;
                  tabcr_in  = 1'b0;
                  sign_in   = 1'b0;
                  digit_in  = 1'b0;
                  num_ok_in = 1'b0;
                  sym_ok_in = 1'b0;
                  if (stcls_pkg::is_single(c)) begin
                     second = single_tok;
                     n      = 2'd2;
                  end else if (c == stcls_pkg::CH_SEMI) begin
                     mode_in = MODE_COMMENT;
                  end
               end else if (stcls_pkg::is_trim(c)) begin
                  pend_in = pend_sat;
                  if (c != stcls_pkg::CH_SPACE) begin
                     tabcr_in = 1'b1;
                  end
               end else begin
                  kept_in   = kept_sat;
                  pend_in   = '0;
                  tabcr_in  = 1'b0;
                  digit_in  = digit_ff | stcls_pkg::is_digit(c);
                  num_ok_in = num_ok_ff && (pend_ff == '0) && stcls_pkg::is_digit(c);
                  sym_ok_in = sym_ok_ff && !tabcr_ff &&
                              (stcls_pkg::is_alnum(c) || (c == stcls_pkg::CH_SLASH));
               end
            end
            MODE_COMMENT: begin
               if (c == stcls_pkg::CH_LF) begin
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               priority if (stcls_pkg::is_space(c)) begin
                  mode_in = MODE_IDLE;
               end else if (stcls_pkg::is_single(c)) begin
                  first = single_tok;
                  n     = 2'd1;
               end else if (c == stcls_pkg::CH_SEMI) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  mode_in   = MODE_RUN;
                  kept_in   = LEN_W'(1);
                  pend_in   = '0;
                  tabcr_in  = 1'b0;
                  sign_in   = (c == stcls_pkg::CH_PLUS) || (c == stcls_pkg::CH_MINUS);
                  digit_in  = stcls_pkg::is_digit(c);
                  num_ok_in = (c == stcls_pkg::CH_PLUS) || (c == stcls_pkg::CH_MINUS) ||
                              stcls_pkg::is_digit(c);
                  sym_ok_in = stcls_pkg::is_alnum(c) || (c == stcls_pkg::CH_SLASH);
               end
            end
         endcase
      end
   end

   always_comb begin
      res.first              = first;
      res.second             = second;
      res.first.last_of_run  = (n == 2'd1);
      res.second.last_of_run = 1'b1;
      res.count              = fire ? n : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         kept_ff   <= '0;
         pend_ff   <= '0;
         tabcr_ff  <= 1'b0;
         sign_ff   <= 1'b0;
         digit_ff  <= 1'b0;
         num_ok_ff <= 1'b0;
         sym_ok_ff <= 1'b0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         kept_ff   <= kept_in;
         pend_ff   <= pend_in;
         tabcr_ff  <= tabcr_in;
         sign_ff   <= sign_in;
         digit_ff  <= digit_in;
         num_ok_ff <= num_ok_in;
         sym_ok_ff <= sym_ok_in;
      end
   end

   // end mark always closes with an end token and leaves the lexer idle
   `ASSERT_IMPLY(a_end_last_kind, (fire && item.end_of_input) |-> ((n == 2'd1) ? (first.token_kind == stcls_pkg::KIND_END) : (second.token_kind == stcls_pkg::KIND_END)))
   `ASSERT_IMPLY(a_end_goes_idle, (fire && item.end_of_input) |=> (mode_ff == MODE_IDLE) && (kept_ff == '0))

endmodule

### rtl/stcls_rsp_queue.sv
// small shifting result queue, takes up to two items per cycle
`include "assert_macros.svh"

module stcls_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  stcls_pkg::res_pair_type push,
   input  logic                    pop,
   output stcls_pkg::rsp_type      head,
   output logic                    nonempty,
   output logic                    room
);

   localparam int DEPTH = stcls_pkg::RSP_QUEUE_DEPTH;
   localparam int CNT_W = stcls_pkg::RSP_QUEUE_CNT_W;

   stcls_pkg::rsp_type slot_ff [DEPTH];
   stcls_pkg::rsp_type slot_in [DEPTH];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   base;

   assign base     = count_ff - CNT_W'(pop);
   assign count_in = base + CNT_W'(push.count);
   assign head     = slot_ff[0];
   assign nonempty = (count_ff != '0);
   assign room     = (count_ff <= CNT_W'(DEPTH - 2));

   always_comb begin
      for (int i = 0; i < DEPTH - 1; i++) begin
         slot_in[i] = pop ? slot_ff[i+1] : slot_ff[i];
      end
      slot_in[DEPTH-1] = slot_ff[DEPTH-1];
      for (int i = 0; i < DEPTH; i++) begin
         if ((push.count != 2'd0) && (base == CNT_W'(i))) begin
            slot_in[i] = push.first;
         end
         if ((push.count == 2'd2) && (base + CNT_W'(1) == CNT_W'(i))) begin
            slot_in[i] = push.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `ASSERT_IMPLY(a_push_has_room, (push.count != 2'd0) |-> (count_ff <= CNT_W'(DEPTH - 2)))
   `ASSERT_ALWAYS(a_count_bound, (count_ff <= CNT_W'(DEPTH)) && (push.count != 2'd3))

endmodule

### rtl/sexpr_token_classifier_top.sv
// s-expression token classifier: top level with input register and result queue
// path: an accepted item is held in the input register until the result queue has room for
//   two results; the lexer then classifies it and the results are registered in the queue
// throughput: one item per cycle while the queue has room; an item with two results sends
//   two tokens, and the four-entry result queue buffers them, stalling input when it lacks room
// reset: synchronous, active high; lexer returns to idle between tokens, input
//   register and result queue empty
`include "assert_macros.svh"

module sexpr_token_classifier_top #(
   parameter int MAX_TOKEN_LENGTH = stcls_pkg::MAX_TOKEN_LENGTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  stcls_pkg::req_type req_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output stcls_pkg::rsp_type rsp_item
);

   // input register, holds one item for the lexer
   logic               in_valid_ff, in_valid_in;
   stcls_pkg::req_type in_item_ff, in_item_in;

   // lexer handshake: consume the held item when the queue can take two results
   logic                    queue_room;
   logic                    lexer_fire;
   stcls_pkg::res_pair_type lexer_res;
   logic                    rsp_pop;

   assign lexer_fire = in_valid_ff && queue_room;
   // register frees up in the same cycle the lexer consumes it
   assign req_ready  = !in_valid_ff || lexer_fire;
   assign rsp_pop    = rsp_valid && rsp_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end else if (lexer_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   // per-byte classification and run state
   stcls_lexer #(
      .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
   ) u_lexer (
      .clock(clock),
      .reset(reset),
      .fire (lexer_fire),
      .item (in_item_ff),
      .res  (lexer_res)
   );

   // result queue, output side reads its head register
   stcls_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (lexer_res),
      .pop     (rsp_pop),
      .head    (rsp_item),
      .nonempty(rsp_valid),
      .room    (queue_room)
   );

   // a held item that the lexer did not take must still be there next cycle
   `ASSERT_IMPLY(a_held_item_kept, (in_valid_ff && !lexer_fire && !reset) |=> (in_valid_ff && $stable(in_item_ff)))

endmodule

### dv/tb_top.sv
// testbench for the s-expression token classifier: directed, long-run and random streams
`timescale 1ns / 1ps

module tb_top;
   import stcls_pkg::*;

   // run limits
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned SETTLE_TICKS = 12;
   localparam int unsigned LEN_CAP      = MAX_TOKEN_LENGTH_DEF;

   // control bytes the package does not name
   localparam logic [7:0] CH_VT = 8'h0B;
   localparam logic [7:0] CH_FF = 8'h0C;

   typedef enum logic [1:0] {
      LEX_IDLE    = 2'd0,
      LEX_RUN     = 2'd1,
      LEX_COMMENT = 2'd2
   } lex_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   // idling knobs, percent per cycle
   int unsigned sender_gap_pct = 0;
   int unsigned sink_stall_pct = 0;
   // long receiver hold-off, counted down by the receiver process
   int unsigned hold_cycles    = 0;

   int unsigned mismatch_count = 0;

   // tokens still owed by the block, oldest first
   rsp_type token_queue[$];
   rsp_type token_due;

   // shadow lexer state
   lex_mode_type lex_mode;
   int unsigned  run_kept;
   int unsigned  run_blanks;
   bit           run_blank_hard;
   bit           run_signed;
   bit           run_digit;
   bit           run_num_ok;
   bit           run_sym_ok;

   // tokens raised by the item being predicted
   rsp_type     step_tokens[2];
   int unsigned step_count;

   // bytes of one random chunk before they go out
   req_type stream_chunk[$];

   sexpr_token_classifier_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // character classes of the token grammar
   // ---------------------------------------------------------------

   function automatic logic lx_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic lx_symbol_char(input logic [7:0] c);
      return lx_digit(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
             (c == CH_SLASH);
   endfunction

   // c-locale whitespace skipped between tokens
   function automatic logic lx_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // bytes that end a run and are then handled between tokens
   function automatic logic lx_breaks(input logic [7:0] c);
      return (c == CH_OPEN) || (c == CH_CLOSE) || (c == CH_DOT) || (c == CH_COMMA) ||
             (c == CH_SEMI) || (c == CH_LF);
   endfunction

   // trailing bytes that are trimmed off a run
   function automatic logic lx_trim(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
   endfunction

   function automatic int unsigned cap_len(input int unsigned v);
      return (v > LEN_CAP) ? LEN_CAP : v;
   endfunction

   // ---------------------------------------------------------------
   // shadow lexer
   // ---------------------------------------------------------------

   function automatic void clear_lexer();
      lex_mode       = LEX_IDLE;
      run_kept       = 0;
      run_blanks     = 0;
      run_blank_hard = 1'b0;
      run_signed     = 1'b0;
      run_digit      = 1'b0;
      run_num_ok     = 1'b0;
      run_sym_ok     = 1'b0;
   endfunction

   function automatic void note_token(input kind_type k, input int unsigned len);
      rsp_type t;
      t.token_kind   = k;
      t.token_length = (len > 255) ? 8'd255 : len[7:0];
      t.last_of_run  = 1'b0;
      step_tokens[step_count] = t;
      step_count++;
   endfunction

   // number wins over symbol, anything else is bad
   function automatic void close_run();
      kind_type k;
      if (run_num_ok && run_digit)
         k = KIND_NUMBER;
      else if (run_sym_ok)
         k = KIND_SYMBOL;
      else
         k = KIND_BAD;
      note_token(k, run_kept);
      clear_lexer();
   endfunction

   function automatic void idle_char(input logic [7:0] c);
      if (lx_space(c))
         return;
      case (c)
         CH_DOT:   note_token(KIND_DOT, 1);
         CH_COMMA: note_token(KIND_COMMA, 1);
         CH_OPEN:  note_token(KIND_OPEN, 1);
         CH_CLOSE: note_token(KIND_CLOSE, 1);
         CH_QUOTE: note_token(KIND_QUOTE, 1);
         CH_SEMI:  lex_mode = LEX_COMMENT;
         default: begin
            // any other byte opens a run
            lex_mode       = LEX_RUN;
            run_kept       = 1;
            run_blanks     = 0;
            run_blank_hard = 1'b0;
            run_signed     = (c == CH_PLUS) || (c == CH_MINUS);
            run_digit      = lx_digit(c);
            run_num_ok     = run_signed || run_digit;
            run_sym_ok     = lx_symbol_char(c);
         end
      endcase
   endfunction

   function automatic void run_char(input logic [7:0] c);
      if (lx_breaks(c)) begin
         close_run();
         idle_char(c);
      end else if (lx_trim(c)) begin
         // held back until a kept byte follows
         run_blanks = cap_len(run_blanks + 1);
         if (c != CH_SPACE)
            run_blank_hard = 1'b1;
      end else begin
         run_kept = cap_len(run_kept + run_blanks + 1);
         if (run_blanks != 0)
            run_num_ok = 1'b0;
         if (run_blank_hard)
            run_sym_ok = 1'b0;
         run_blanks     = 0;
         run_blank_hard = 1'b0;
         if (lx_digit(c))
            run_digit = 1'b1;
         else
            run_num_ok = 1'b0;
         if (!lx_symbol_char(c))
            run_sym_ok = 1'b0;
      end
   endfunction

   // work out the tokens of one accepted item and queue them
   function automatic void predict_item(input req_type it);
      rsp_type t;
      step_count = 0;
      if (it.end_of_input) begin
         if (lex_mode == LEX_RUN)
            close_run();
         note_token(KIND_END, 0);
         clear_lexer();
      end else begin
         case (lex_mode)
            LEX_RUN: run_char(it.char_byte);
            LEX_COMMENT: begin
               if (it.char_byte == CH_LF)
                  lex_mode = LEX_IDLE;
            end
            default: idle_char(it.char_byte);
         endcase
      end
      for (int unsigned k = 0; k < step_count; k++) begin
         t             = step_tokens[k];
         t.last_of_run = (k == step_count - 1);
         token_queue.push_back(t);
      end
   endfunction

   // ---------------------------------------------------------------
   // receiver side and result check
   // ---------------------------------------------------------------

   // random stalls, or a long hold-off when one is armed
   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // each taken token against the oldest one owed, as kind/length/last
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (token_queue.size() == 0) begin
            $display("%0t: token with none owed: kind %0d length %0d last %0b",
                     $time, rsp_item.token_kind, rsp_item.token_length,
                     rsp_item.last_of_run);
            mismatch_count++;
         end else begin
            token_due = token_queue.pop_front();
            if (rsp_item.token_kind !== token_due.token_kind ||
                rsp_item.token_length !== token_due.token_length ||
                rsp_item.last_of_run !== token_due.last_of_run) begin
               $display("%0t: token mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                        $time, token_due.token_kind, token_due.token_length,
                        token_due.last_of_run, rsp_item.token_kind,
                        rsp_item.token_length, rsp_item.last_of_run);
               mismatch_count++;
            end
         end
      end
   end

   // hard stop if the block hangs
   initial begin : watchdog
      int unsigned cycles_run;
      cycles_run = 0;
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("tb_top failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------

   function automatic req_type make_item(input logic [7:0] c, input logic eoi);
      req_type it;
      it.char_byte    = c;
      it.end_of_input = eoi;
      return it;
   endfunction

   // offer one item, predict on acceptance, then maybe go idle for a while
   task automatic send_item(input req_type it);
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_item(it);
      if (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < sender_gap_pct);
      end
   endtask

   task automatic send_char(input logic [7:0] c);
      send_item(make_item(c, 1'b0));
   endtask

   task automatic send_end(input logic [7:0] c);
      send_item(make_item(c, 1'b1));
   endtask

   // called in the step of the last acceptance
   task automatic drop_valid();
      req_valid <= 1'b0;
   endtask

   // pause until every owed token is back, then let the pipe settle
   task automatic wait_drained();
      while (token_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // random byte sources
   // ---------------------------------------------------------------

   function automatic logic [7:0] random_byte();
      logic [7:0] b;
      b = $urandom_range(255);
      return b;
   endfunction

   function automatic logic [7:0] random_digit();
      int unsigned r;
      r = $urandom_range(9);
      return 8'h30 + r[7:0];
   endfunction

   // letters, digits, slash and space
   function automatic logic [7:0] random_symbol_char();
      int unsigned r;
      r = $urandom_range(63);
      if (r < 10)
         return 8'h30 + r[7:0];
      if (r < 36)
         return 8'h61 + r[7:0] - 8'd10;
      if (r < 62)
         return 8'h41 + r[7:0] - 8'd36;
      return (r == 62) ? CH_SLASH : CH_SPACE;
   endfunction

   function automatic logic [7:0] random_single();
      case ($urandom_range(4))
         0:       return CH_DOT;
         1:       return CH_COMMA;
         2:       return CH_OPEN;
         3:       return CH_CLOSE;
         default: return CH_QUOTE;
      endcase
   endfunction

   // trim bytes only, or any c-locale whitespace
   function automatic logic [7:0] random_blank(input bit trim_only);
      case (trim_only ? $urandom_range(2) : $urandom_range(5))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_CR;
         3:       return CH_LF;
         4:       return CH_VT;
         default: return CH_FF;
      endcase
   endfunction

   function automatic void add_char(input logic [7:0] c);
      stream_chunk.push_back(make_item(c, 1'b0));
   endfunction

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // each single-byte token, and whitespace skipped between tokens
   task automatic test_single_char_tokens();
      sender_gap_pct = 0;
      sink_stall_pct = 0;
      send_char(CH_DOT);
      send_char(CH_COMMA);
      send_char(CH_OPEN);
      send_char(CH_CLOSE);
      send_char(CH_QUOTE);
      send_char(CH_TAB);
      send_char(CH_VT);
      send_char(CH_FF);
      drop_valid();
      wait_drained();
   endtask

   // signed number with trailing blanks cut by a dot, symbol with space and slash
   task automatic test_run_kinds();
      send_char(CH_PLUS);
      send_char("4");
      send_char("2");
      send_char(CH_SPACE);
      send_char(CH_TAB);
      send_char(CH_DOT);
      send_char("a");
      send_char(CH_SPACE);
      send_char(CH_SLASH);
      send_char("9");
      send_char(CH_LF);
      drop_valid();
      wait_drained();
   endtask

   // high bytes, nul, vt and quote inside a run, end inside a comment
   task automatic test_special_bytes();
      send_char(8'h80);
      send_char(8'h00);
      send_char(CH_VT);
      send_char(CH_QUOTE);
      send_char(8'hFF);
      send_end(8'hFF);
      send_char(CH_SEMI);
      send_char("a");
      send_end(8'h00);
      drop_valid();
      wait_drained();
   endtask

   // blank count runs past the cap, and so does the kept length once a byte follows
   task automatic test_long_runs();
      sender_gap_pct = 0;
      sink_stall_pct = 0;
      send_char("x");
      for (int unsigned k = 0; k < 256; k++)
         send_char(CH_SPACE);
      send_char("y");
      send_end(8'h00);
      drop_valid();
      wait_drained();
   endtask

   // mostly well-formed token chunks with random content, some noise
   task automatic test_random_stream(input int unsigned gap_pct, input int unsigned stall_pct,
                                     input int unsigned item_total);
      int unsigned sent;
      int unsigned pick;
      int unsigned len;
      sender_gap_pct = gap_pct;
      sink_stall_pct = stall_pct;
      sent = 0;
      while (sent < item_total) begin
         stream_chunk.delete();
         pick = $urandom_range(99);
         if (pick < 12) begin
            add_char(random_single());
         end else if (pick < 20) begin
            len = $urandom_range(1, 3);
            for (int unsigned k = 0; k < len; k++)
               add_char(random_blank(1'b0));
         end else if (pick < 40) begin
            // number, sometimes split by a space, maybe trailing blanks
            if ($urandom_range(1))
               add_char($urandom_range(1) ? CH_PLUS : CH_MINUS);
            len = $urandom_range(1, 4);
            for (int unsigned k = 0; k < len; k++)
               add_char(random_digit());
            if ($urandom_range(3) == 0) begin
               add_char(CH_SPACE);
               add_char(random_digit());
            end
            len = $urandom_range(2);
            for (int unsigned k = 0; k < len; k++)
               add_char(random_blank(1'b1));
         end else if (pick < 60) begin
            len = $urandom_range(1, 6);
            for (int unsigned k = 0; k < len; k++)
               add_char(random_symbol_char());
         end else if (pick < 70) begin
            len = $urandom_range(1, 5);
            for (int unsigned k = 0; k < len; k++)
               add_char(random_byte());
         end else if (pick < 78) begin
            // comment up to a newline
            add_char(CH_SEMI);
            len = $urandom_range(4);
            for (int unsigned k = 0; k < len; k++)
               add_char(random_byte());
            add_char(CH_LF);
         end else if (pick < 83) begin
            // blank or control byte between two symbol characters
            add_char(random_symbol_char());
            add_char(random_blank(1'b0) == CH_LF ? CH_TAB : random_blank(1'b0));
            add_char(random_symbol_char());
         end else if (pick < 88) begin
            stream_chunk.push_back(make_item(random_byte(), 1'b1));
         end else begin
            len = $urandom_range(1, 3);
            for (int unsigned k = 0; k < len; k++)
               add_char(random_byte());
         end
         for (int unsigned k = 0; k < stream_chunk.size(); k++)
            send_item(stream_chunk[k]);
         // whitespace between tokens only gets skipped
         if (pick < 12 || pick >= 20)
            sent += stream_chunk.size();
      end
      drop_valid();
      wait_drained();
   endtask

   // receiver holds off long enough for the block to fill and stall its input
   task automatic test_backpressure();
      sender_gap_pct = 0;
      sink_stall_pct = 0;
      hold_cycles <= 300;
      for (int unsigned k = 0; k < 40; k++) begin
         if (k % 8 == 7)
            send_char("z");
         else
            send_char(random_single());
      end
      drop_valid();
      wait_drained();
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------

   initial begin
      clear_lexer();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_single_char_tokens();
      test_run_kinds();
      test_special_bytes();
      test_long_runs();
      test_random_stream(0, 0, 60);
      test_random_stream(85, 0, 50);
      test_random_stream(0, 85, 50);
      test_random_stream(26, 26, 60);
      test_backpressure();

      if (mismatch_count == 0 && token_queue.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
